// File: rtl/core/rpkd_pkg.sv
// ----------------------------------------------------------------------------
// rpkd_pkg
// Shared widths, status codes and handshake types for the RSA key derivation.
// ----------------------------------------------------------------------------
`default_nettype none

package rpkd_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned PRIME_WIDTH_DEF = 16;
  localparam int unsigned STATUS_W        = 3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_ZERO_PRIME  = 3'd1,
    STAT_EQUAL_PRIME = 3'd2,
    STAT_ZERO_EXP    = 3'd3,
    STAT_NOT_COPRIME = 3'd4
  } status_e;

  // Completion report of a serial unit.
  typedef struct packed {
    logic done;  // one-cycle pulse
    logic ok;    // result exists (inverse unit only)
  } unit_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/rsa_private_key_derivation_top.sv
// ----------------------------------------------------------------------------
// rsa_private_key_derivation_top
// Derives modulus, totient and private exponent from two primes and e.
// ----------------------------------------------------------------------------
// One request at a time. Both products come from bit-serial multipliers; the
// inverse then runs a reduction of e plus one serial division per Euclid
// step. A request that stops at an early check (zero prime, equal primes,
// zero e) skips the inverse, and the length of a full derivation is set by
// the number of Euclid steps in the serial division loop. A new request is
// taken while the previous result still waits in the output register.
`default_nettype none

module rsa_private_key_derivation_top #(
  parameter int unsigned PRIME_WIDTH = rpkd_pkg::PRIME_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // prime_p, prime_q, pub_exp, zero fill
  input  wire logic [((2*PRIME_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // key_modulus, totient, priv_exp, status, zero fill
  output logic [103:0]                               m_axis_tdata
);
  import rpkd_pkg::*;

  localparam int unsigned OUT_W = 3*WORD_W + STATUS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_INV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [PRIME_WIDTH-1:0] p_q, q_q, in_p, in_q;
  logic [WORD_W-1:0]      e_q, in_e, mod_q, mod_d, tot_q, tot_d, d_q, d_d;
  logic [WORD_W-1:0]      mod_prod, tot_prod, inv_val;
  status_e                st_q, st_d;
  unit_rsp_t              mul_rsp, tmul_rsp, inv_rsp;
  logic                   accept, inv_start, load_out;
  logic                   out_valid_q;
  logic [103:0]           out_data_q;

  assign in_p   = s_axis_tdata[PRIME_WIDTH-1:0];
  assign in_q   = s_axis_tdata[2*PRIME_WIDTH-1:PRIME_WIDTH];
  assign in_e   = s_axis_tdata[2*PRIME_WIDTH+WORD_W-1:2*PRIME_WIDTH];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  rpkd_mul #(.PRIME_WIDTH(PRIME_WIDTH)) u_mod_mul (
    .clk_i, .rst_ni, .start_i(accept), .a_i(in_p), .b_i(in_q),
    .rsp_o(mul_rsp), .prod_o(mod_prod)
  );

  rpkd_mul #(.PRIME_WIDTH(PRIME_WIDTH)) u_tot_mul (
    .clk_i, .rst_ni, .start_i(accept),
    .a_i(in_p - PRIME_WIDTH'(1)), .b_i(in_q - PRIME_WIDTH'(1)),
    .rsp_o(tmul_rsp), .prod_o(tot_prod)
  );

  rpkd_inv u_inv (
    .clk_i, .rst_ni, .start_i(inv_start), .e_i(e_q), .m_i(tot_prod),
    .rsp_o(inv_rsp), .inv_o(inv_val)
  );

  always_comb begin
    state_d = state_q;
    mod_d = mod_q; tot_d = tot_q; d_d = d_q; st_d = st_q;
    inv_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_MUL;
      S_MUL: begin
        if (mul_rsp.done) begin
          mod_d = '0; tot_d = '0; d_d = '0;
          if (p_q == '0 || q_q == '0) begin
            st_d = STAT_ZERO_PRIME; state_d = S_OUT;
          end else if (p_q == q_q) begin
            mod_d = mod_prod; st_d = STAT_EQUAL_PRIME; state_d = S_OUT;
          end else if (e_q == '0) begin
            mod_d = mod_prod; tot_d = tot_prod; st_d = STAT_ZERO_EXP;
            state_d = S_OUT;
          end else begin
            mod_d = mod_prod; tot_d = tot_prod; inv_start = 1'b1;
            state_d = S_INV;
          end
        end
      end
      S_INV: begin
        if (inv_rsp.done) begin
          d_d  = inv_rsp.ok ? inv_val : '0;
          st_d = inv_rsp.ok ? STAT_OK : STAT_NOT_COPRIME;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= in_p;
      q_q <= in_q;
      e_q <= in_e;
    end
    mod_q <= mod_d; tot_q <= tot_d; d_q <= d_d; st_q <= st_d;
    if (load_out) out_data_q <= {(104 - OUT_W)'(0), st_q, d_q, tot_q, mod_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // both multipliers run in lockstep
  a_mul_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done == tmul_rsp.done)
    else $error("multipliers out of step");

  // a valid private exponent lies below the totient
  a_d_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && st_q == STAT_OK) |-> (d_q < tot_q))
    else $error("private exponent not reduced");

  // a zero prime yields an all-zero result
  a_zero_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && st_q == STAT_ZERO_PRIME) |-> (mod_q == '0 && tot_q == '0 && d_q == '0))
    else $error("zero prime result not cleared");

  // the inverse unit only reports while a derivation waits for it
  a_inv_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inv_rsp.done |-> (state_q == S_INV))
    else $error("stray inverse completion");

endmodule

`default_nettype wire

// File: rtl/core/rpkd_mul.sv
// ----------------------------------------------------------------------------
// rpkd_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, 32-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module rpkd_mul #(
  parameter int unsigned PRIME_WIDTH = rpkd_pkg::PRIME_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [PRIME_WIDTH-1:0]      a_i,
  input  wire logic [PRIME_WIDTH-1:0]      b_i,
  output rpkd_pkg::unit_rsp_t              rsp_o,
  output logic [rpkd_pkg::WORD_W-1:0]      prod_o
);
  import rpkd_pkg::*;

  localparam int unsigned CNT_W = $clog2(PRIME_WIDTH + 1);

  logic [WORD_W-1:0]      a_q, acc_q;
  logic [PRIME_WIDTH-1:0] b_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PRIME_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= WORD_W'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ok   = 1'b1;
  assign prod_o     = acc_q;

endmodule

`default_nettype wire

// File: rtl/core/rpkd_inv.sv
// ----------------------------------------------------------------------------
// rpkd_inv
// Modular inverse by extended Euclid; each quotient is found bit-serially by
// restoring division while q*t1 mod m is built by Horner steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rpkd_inv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rpkd_pkg::WORD_W-1:0] e_i,
  input  wire logic [rpkd_pkg::WORD_W-1:0] m_i,
  output rpkd_pkg::unit_rsp_t              rsp_o,
  output logic [rpkd_pkg::WORD_W-1:0]      inv_o
);
  import rpkd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVA = 3'd1;
  localparam logic [2:0] S_DIVB = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic [2:0]        state_q, state_d;
  logic [WORD_W-1:0] r0_q, r1_q, t0_q, t1_q, m_q, dv_q;
  logic [WORD_W-1:0] r0_d, r1_d, t0_d, t1_d, dv_d;
  logic [WORD_W:0]   rem_q, rem_d, acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              qbit_q, qbit_d, red_q, red_d;
  logic              done_q, done_d, ok_q, ok_d;
  logic [WORD_W:0]   rem_sh, acc_sh, acc_add, t_diff;

  always_comb begin
    state_d = state_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q; dv_d = dv_q;
    rem_d = rem_q; acc_d = acc_q; cnt_d = cnt_q; qbit_d = qbit_q; red_d = red_q;
    done_d = 1'b0; ok_d = ok_q;
    rem_sh  = {rem_q[WORD_W-1:0], dv_q[WORD_W-1]};
    acc_sh  = {acc_q[WORD_W-1:0], 1'b0};
    acc_add = acc_q + {1'b0, t1_q};
    t_diff  = ({1'b0, t0_q} >= acc_q) ? {1'b0, t0_q} - acc_q
                                      : {1'b0, t0_q} + {1'b0, m_q} - acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (m_i == '0) begin
            done_d = 1'b1;
            ok_d   = 1'b0;
          end else begin
            // first pass reduces e modulo m
            dv_d = e_i; r1_d = m_i; rem_d = '0; acc_d = '0;
            cnt_d = '0; red_d = 1'b1; state_d = S_DIVA;
          end
        end
      end
      S_DIVA: begin
        if (rem_sh >= {1'b0, r1_q}) begin
          rem_d = rem_sh - {1'b0, r1_q}; qbit_d = 1'b1;
        end else begin
          rem_d = rem_sh; qbit_d = 1'b0;
        end
        dv_d  = dv_q << 1;
        acc_d = (acc_sh >= {1'b0, m_q}) ? acc_sh - {1'b0, m_q} : acc_sh;
        state_d = S_DIVB;
      end
      S_DIVB: begin
        if (qbit_q)
          acc_d = (acc_add >= {1'b0, m_q}) ? acc_add - {1'b0, m_q} : acc_add;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q == CNT_W'(WORD_W - 1)) ? S_STEP : S_DIVA;
      end
      S_STEP: begin
        if (red_q) begin
          r0_d = m_q;
          r1_d = rem_q[WORD_W-1:0];
          t0_d = '0;
          t1_d = (m_q == WORD_W'(1)) ? '0 : WORD_W'(1);
          red_d = 1'b0;
        end else begin
          r0_d = r1_q;
          r1_d = rem_q[WORD_W-1:0];
          t0_d = t1_q;
          t1_d = t_diff[WORD_W-1:0];
        end
        if (rem_q == '0) begin
          state_d = S_FIN;
        end else begin
          dv_d = r0_d; rem_d = '0; acc_d = '0; cnt_d = '0;
          state_d = S_DIVA;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        ok_d    = (r0_q == WORD_W'(1));
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      red_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      red_q   <= red_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d; dv_q <= dv_d;
    rem_q <= rem_d; acc_q <= acc_d; qbit_q <= qbit_d; ok_q <= ok_d;
    if (state_q == S_IDLE && start_i) m_q <= m_i;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ok   = ok_q;
  assign inv_o      = t0_q;

  // the coefficient never leaves [0, m)
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (t0_q < m_q))
    else $error("inverse coefficient out of range");

  // remainder stays below the divisor after each restoring step
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVB) |-> (rem_q < {1'b0, r1_q}))
    else $error("division remainder not reduced");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives prime pairs and exponents into the key derivation block, predicts
// modulus, totient, private exponent and status, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

class key_scoreboard;
  logic [103:0] pending_keys[$];
  int unsigned  fail_count;

  // Extended Euclid; returns 0 when no inverse exists.
  static function automatic bit find_inverse(longint unsigned e, longint unsigned m,
                                             output longint unsigned inv);
    longint unsigned r0, r1, qt, tmp;
    longint t0, t1, tt;
    inv = 0;
    if (m == 0) return 0;
    r0 = m;
    r1 = e % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt  = r0 / r1;
      tmp = r0 - qt * r1;
      r0  = r1;
      r1  = tmp;
      tt  = t0 - longint'(qt) * t1;
      t0  = t1;
      t1  = tt;
    end
    if (r0 != 1) return 0;
    if (t0 < 0) t0 += longint'(m);
    inv = longint'(t0) % m;
    return 1;
  endfunction

  function void note_request(logic [15:0] p, logic [15:0] q, logic [31:0] e);
    longint unsigned modv, tot, d;
    rpkd_pkg::status_e st;
    modv = 0;
    tot  = 0;
    d    = 0;
    st   = rpkd_pkg::STAT_OK;
    if (p == 0 || q == 0) begin
      st = rpkd_pkg::STAT_ZERO_PRIME;
    end else begin
      modv = (longint'(p) * q) & 32'hFFFF_FFFF;
      if (p == q) begin
        st = rpkd_pkg::STAT_EQUAL_PRIME;
      end else begin
        tot = (longint'(p - 1) * (q - 1)) & 32'hFFFF_FFFF;
        if (e == 0) st = rpkd_pkg::STAT_ZERO_EXP;
        else if (!find_inverse(e, tot, d)) begin
          st = rpkd_pkg::STAT_NOT_COPRIME;
          d  = 0;
        end
      end
    end
    pending_keys.push_back({5'd0, st, d[31:0], tot[31:0], modv[31:0]});
  endfunction

  function void check_key(logic [103:0] got);
    logic [103:0] want;
    if (pending_keys.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fail_count++;
      return;
    end
    want = pending_keys.pop_front();
    if (got[31:0] !== want[31:0])
      $display("%0t: key_modulus expected %h actual %h", $time, want[31:0], got[31:0]);
    if (got[63:32] !== want[63:32])
      $display("%0t: totient expected %h actual %h", $time, want[63:32], got[63:32]);
    if (got[95:64] !== want[95:64])
      $display("%0t: priv_exp expected %h actual %h", $time, want[95:64], got[95:64]);
    if (got[98:96] !== want[98:96])
      $display("%0t: status expected %0d actual %0d", $time, want[98:96], got[98:96]);
    if (got[103:99] !== want[103:99])
      $display("%0t: fill expected %h actual %h", $time, want[103:99], got[103:99]);
    if (got !== want) fail_count++;
  endfunction
endclass

module testbench;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;   // prime_p, prime_q, pub_exp
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;   // key_modulus, totient, priv_exp, status, zero fill

  key_scoreboard key_sb;
  int unsigned   idle_cycles;
  bit            stall_mode;

  rsa_private_key_derivation_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output side: check accepted results, stall on a changing pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) key_sb.check_key(m_axis_tdata);
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [15:0] p, logic [15:0] q, logic [31:0] e);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e, q, p};
    do @(posedge clk_i); while (!s_axis_tready);
    key_sb.note_request(p, q, e);
  endtask

  task automatic pause_sender();
    int unsigned gap;
    gap = $urandom_range(1, 12);
    s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_prime();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'hFFFF - 16'($urandom_range(0, 3));
      2, 3:    return 16'($urandom_range(2, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_exp();
    case ($urandom_range(0, 9))
      0:       return 32'($urandom_range(0, 3));
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      2, 3:    return 32'd65537;
      4:       return 32'($urandom_range(2, 1000));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned burst;
    int unsigned wait_count;
    logic [15:0] rp;
    key_sb        = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_mode    = 1'b0;
    idle_cycles   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero prime, equal primes, zero e, zero totient, not coprime, extremes.
    send_request(16'd0, 16'd7, 32'd3);
    send_request(16'd11, 16'd0, 32'd3);
    send_request(16'd13, 16'd13, 32'd5);
    send_request(16'd61, 16'd53, 32'd0);
    send_request(16'd1, 16'd7, 32'd5);
    send_request(16'd2, 16'd3, 32'd5);
    send_request(16'd2, 16'd3, 32'd0);
    send_request(16'd61, 16'd53, 32'd17);
    send_request(16'd61, 16'd53, 32'd6);
    send_request(16'd61, 16'd53, 32'hFFFF_FFFF);
    send_request(16'hFFF1, 16'hFFFB, 32'd65537);
    send_request(16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF);
    send_request(16'hFFFF, 16'hFFFF, 32'd3);
    send_request(16'hFFFF, 16'h8000, 32'h8000_0001);
    send_request(16'd3, 16'd5, 32'd7);
    pause_sender();

    // Random: mostly p != q with well-formed inputs, bursts with gaps.
    for (int unsigned n = 0; n < 450; ) begin
      burst = $urandom_range(1, 8);
      for (int unsigned b = 0; b < burst; b++) begin
        rp = pick_prime();
        send_request(rp, ($urandom_range(0, 19) == 0) ? rp : pick_prime(), pick_exp());
        n++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    s_axis_tvalid <= 1'b0;

    wait_count = 0;
    while (key_sb.pending_keys.size() != 0 && wait_count < 200000) begin
      @(posedge clk_i);
      wait_count++;
    end
    repeat (100) @(posedge clk_i);
    if (key_sb.pending_keys.size() == 0 && key_sb.fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire
